FILE: hdl/tmtb_pkg.sv
// Shared types and operation codes for the timeout timer bank.
package tmtb_pkg;

   localparam int ID_W   = 4;
   localparam int FUNC_W = 4;
   localparam int TIME_W = 32;
   localparam int MASK_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR_ALL = 4'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET_ONCE  = 4'd1;
   localparam logic [FUNC_W-1:0] FUNC_SET_REP   = 4'd2;
   localparam logic [FUNC_W-1:0] FUNC_START     = 4'd3;
   localparam logic [FUNC_W-1:0] FUNC_STOP      = 4'd4;
   localparam logic [FUNC_W-1:0] FUNC_QUERY     = 4'd5;
   localparam logic [FUNC_W-1:0] FUNC_RESTART   = 4'd6;
   localparam logic [FUNC_W-1:0] FUNC_ELAPSED   = 4'd7;
   localparam logic [FUNC_W-1:0] FUNC_TICK      = 4'd8;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   timer_id;
      logic [TIME_W-1:0] interval_ms;
      logic [TIME_W-1:0] now_ms;
   } req_type;

   typedef struct packed {
      logic              timeout_flag;
      logic [TIME_W-1:0] elapsed_ms;
      logic [MASK_W-1:0] flag_mask;
   } rsp_type;

endpackage

FILE: hdl/tmtb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tmtb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/multi_channel_timeout_timer_bank.sv
// Bank of one-shot and repeating timeout timers with periods and start times in RAM.
//
// Usage: present an operation on req_data with start high; it is taken on a
// clock edge where busy is low. Each operation gives exactly one beat on
// rsp_data, marked by a one-cycle rsp_valid strobe; there is no back-pressure.
// How each operation reaches its result after the accepting edge:
//   clear all, set period, start, stop, query flag, restart, unused codes: registered at that edge
//   elapsed query (addressed timer in the bank): one start-time RAM read, then the result
//   tick: the walk reads one timer entry per cycle, then gives the result
// busy is high for the walk and the elapsed read; the other operations
// can be issued on every cycle. The length of a tick's occupancy is thus
// set by the single read port of the period and start RAMs.
// Reset, like clear all, marks every RAM entry as unwritten (reading zero)
// and clears the flag, running and repeat bits at once; no clearing pass.
// flag_mask reports the timeout flags of timers 0 to 15 after the operation.
module multi_channel_timeout_timer_bank
   import tmtb_pkg::*;
#(
   parameter int NUM_TIMERS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int EXT_W = IDX_W + ID_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_ELAP = 2'd1;
   localparam logic [1:0] S_TICK = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [IDX_W-1:0]      cnt_ff, cnt_in;
   req_type               req_ff, req_in;
   logic [NUM_TIMERS-1:0] exp_ff, exp_in;
   logic [NUM_TIMERS-1:0] run_ff, run_in;
   logic [NUM_TIMERS-1:0] rep_ff, rep_in;
   logic [NUM_TIMERS-1:0] pvld_ff, pvld_in;
   logic [NUM_TIMERS-1:0] svld_ff, svld_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [EXT_W-1:0]  id_wide;
   logic [IDX_W-1:0]  id_idx;
   logic              id_ok;
   logic              accept;
   logic              per_we, sta_we;
   logic [IDX_W-1:0]  rd_addr;
   logic [TIME_W-1:0] per_rd, sta_rd;
   logic [TIME_W-1:0] per_val, sta_val, diff;

   assign id_wide = {{IDX_W{1'b0}}, req_data.timer_id};
   assign id_idx  = id_wide[IDX_W-1:0];
   assign id_ok   = id_wide < EXT_W'(NUM_TIMERS);
   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);

   tmtb_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_period_ram (
      .clock   (clock),
      .wr_en   (per_we),
      .wr_addr (id_idx),
      .wr_data (req_data.interval_ms),
      .rd_addr (rd_addr),
      .rd_data (per_rd)
   );

   tmtb_ram #(.WIDTH(TIME_W), .DEPTH(NUM_TIMERS)) u_start_ram (
      .clock   (clock),
      .wr_en   (sta_we),
      .wr_addr (id_idx),
      .wr_data (req_data.now_ms),
      .rd_addr (rd_addr),
      .rd_data (sta_rd)
   );

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      exp_in       = exp_ff;
      run_in       = run_ff;
      rep_in       = rep_ff;
      pvld_in      = pvld_ff;
      svld_in      = svld_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      per_we       = 1'b0;
      sta_we       = 1'b0;
      rd_addr      = (state_ff == S_IDLE) ? id_idx : cnt_ff + IDX_W'(1);
      per_val      = pvld_ff[cnt_ff] ? per_rd : '0;
      sta_val      = svld_ff[cnt_ff] ? sta_rd : '0;
      diff         = req_ff.now_ms - sta_val;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in       = req_data;
               rsp_valid_in = 1'b1;
               unique case (req_data.func) inside
                  FUNC_CLEAR_ALL: begin
                     exp_in  = '0;
                     run_in  = '0;
                     rep_in  = '0;
                     pvld_in = '0;
                     svld_in = '0;
                  end
                  FUNC_SET_ONCE, FUNC_SET_REP: begin
                     if (id_ok) begin
                        per_we          = 1'b1;
                        pvld_in[id_idx] = 1'b1;
                        rep_in[id_idx]  = (req_data.func == FUNC_SET_REP);
                     end
                  end
                  FUNC_START: begin
                     if (id_ok) begin
                        sta_we          = 1'b1;
                        svld_in[id_idx] = 1'b1;
                        exp_in[id_idx]  = 1'b0;
                        run_in[id_idx]  = 1'b1;
                     end
                  end
                  FUNC_STOP: begin
                     if (id_ok) begin
                        run_in[id_idx] = 1'b0;
                     end
                  end
                  FUNC_QUERY: begin
                     rsp_in.timeout_flag = id_ok && exp_ff[id_idx];
                  end
                  FUNC_RESTART: begin
                     if (id_ok) begin
                        sta_we          = 1'b1;
                        svld_in[id_idx] = 1'b1;
                        exp_in[id_idx]  = 1'b0;
                     end
                  end
                  FUNC_ELAPSED: begin
                     if (id_ok) begin
                        rsp_valid_in = 1'b0;
                        cnt_in       = id_idx;
                        state_in     = S_ELAP;
                     end
                  end
                  FUNC_TICK: begin
                     rsp_valid_in = 1'b0;
                     rd_addr      = '0;
                     cnt_in       = '0;
                     state_in     = S_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_ELAP: begin
            rsp_valid_in      = 1'b1;
            rsp_in.elapsed_ms = diff;
            state_in          = S_IDLE;
         end
         S_TICK: begin
            if (run_ff[cnt_ff] && !exp_ff[cnt_ff] && (diff >= per_val)) begin
               exp_in[cnt_ff] = 1'b1;
               if (!rep_ff[cnt_ff]) begin
                  run_in[cnt_ff] = 1'b0;
               end
            end
            if (cnt_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               cnt_in = cnt_ff + IDX_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      for (int i = 0; i < MASK_W; i++) begin
         if (i < NUM_TIMERS) begin
            rsp_in.flag_mask[i] = exp_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         exp_ff       <= '0;
         run_ff       <= '0;
         rep_ff       <= '0;
         pvld_ff      <= '0;
         svld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         exp_ff       <= exp_in;
         run_ff       <= run_in;
         rep_ff       <= rep_in;
         pvld_ff      <= pvld_in;
         svld_ff      <= svld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: test/multi_channel_timeout_timer_bank_tb.sv
// Self-checking testbench for the timeout timer bank: directed and random operations.
module multi_channel_timeout_timer_bank_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tmtb_pkg::*;

   localparam int NUM_TIMERS  = 16;
   localparam int TICK_CYCLES = NUM_TIMERS + 1;
   localparam int IDLE_LIMIT  = 2000;
   localparam int PRINT_LIMIT = 20;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   logic [TIME_W-1:0]     timer_period [NUM_TIMERS];
   logic [TIME_W-1:0]     timer_start  [NUM_TIMERS];
   logic [NUM_TIMERS-1:0] timer_flagged;
   logic [NUM_TIMERS-1:0] timer_running;
   logic [NUM_TIMERS-1:0] timer_repeats;

   rsp_type           awaited_results [$];
   logic [TIME_W-1:0] ms_now;
   int                idle_pct;
   int                error_count;
   int                ops_sent;
   int                ticks_sent;
   int                results_checked;
   int                flagged_results;
   int                quiet_cycles;

   multi_channel_timeout_timer_bank #(
      .NUM_TIMERS(NUM_TIMERS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void bank_clear();
      for (int i = 0; i < NUM_TIMERS; i++) begin
         timer_period[i] = '0;
         timer_start[i]  = '0;
      end
      timer_flagged = '0;
      timer_running = '0;
      timer_repeats = '0;
   endfunction

   function automatic rsp_type bank_predict(req_type op);
      rsp_type           res;
      logic              in_bank;
      logic [TIME_W-1:0] since;
      res     = '0;
      in_bank = op.timer_id < NUM_TIMERS;
      case (op.func)
         FUNC_CLEAR_ALL: bank_clear();
         FUNC_SET_ONCE, FUNC_SET_REP: begin
            if (in_bank) begin
               timer_period[op.timer_id]  = op.interval_ms;
               timer_repeats[op.timer_id] = (op.func == FUNC_SET_REP);
            end
         end
         FUNC_START: begin
            if (in_bank) begin
               timer_start[op.timer_id]   = op.now_ms;
               timer_flagged[op.timer_id] = 1'b0;
               timer_running[op.timer_id] = 1'b1;
            end
         end
         FUNC_STOP: begin
            if (in_bank) timer_running[op.timer_id] = 1'b0;
         end
         FUNC_QUERY: begin
            if (in_bank) res.timeout_flag = timer_flagged[op.timer_id];
         end
         FUNC_RESTART: begin
            if (in_bank) begin
               timer_start[op.timer_id]   = op.now_ms;
               timer_flagged[op.timer_id] = 1'b0;
            end
         end
         FUNC_ELAPSED: begin
            if (in_bank) res.elapsed_ms = op.now_ms - timer_start[op.timer_id];
         end
         FUNC_TICK: begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
               since = op.now_ms - timer_start[i];
               if (timer_running[i] && !timer_flagged[i] && since >= timer_period[i]) begin
                  timer_flagged[i] = 1'b1;
                  if (!timer_repeats[i]) timer_running[i] = 1'b0;
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < NUM_TIMERS && i < MASK_W; i++) res.flag_mask[i] = timer_flagged[i];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                  input logic [TIME_W-1:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
   endtask

   task automatic send_beat(input logic [FUNC_W-1:0] op_func, input logic [ID_W-1:0] op_id,
                            input logic [TIME_W-1:0] op_period, input logic [TIME_W-1:0] op_now);
      req_type beat;
      beat = '{func: op_func, timer_id: op_id, interval_ms: op_period, now_ms: op_now};
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      awaited_results.push_back(bank_predict(beat));
      ops_sent++;
      if (op_func == FUNC_TICK) ticks_sent++;
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (TICK_CYCLES) @(posedge clock);
   endtask

   task automatic test_basic_operations();
      send_beat(FUNC_QUERY, 4'd0, $urandom, $urandom);
      send_beat(FUNC_ELAPSED, 4'd15, '0, 32'hFFFF_FFFF);
      // zero period flags on the first tick
      send_beat(FUNC_SET_ONCE, 4'd0, '0, $urandom);
      send_beat(FUNC_START, 4'd0, $urandom, 32'd100);
      send_beat(FUNC_TICK, 4'd7, $urandom, 32'd100);
      send_beat(FUNC_QUERY, 4'd0, '1, '1);
      // wrapping difference across the top of the count
      send_beat(FUNC_SET_REP, 4'd15, 32'hFFFF_FFFF, '0);
      send_beat(FUNC_START, 4'd15, '0, 32'hFFFF_FFF0);
      send_beat(FUNC_TICK, 4'd0, '0, 32'd5);
      send_beat(FUNC_ELAPSED, 4'd15, $urandom, 32'd5);
      // shorten the period of a running timer
      send_beat(FUNC_SET_REP, 4'd15, 32'h10, $urandom);
      send_beat(FUNC_TICK, 4'd3, $urandom, 32'd6);
      send_beat(FUNC_RESTART, 4'd15, $urandom, '0);
      send_beat(FUNC_STOP, 4'd15, $urandom, $urandom);
      send_beat(FUNC_TICK, 4'd15, '1, 32'hFFFF_FFFF);
   endtask

   task automatic test_unused_codes_and_clear();
      for (int code = FUNC_TICK + 1; code < (1 << FUNC_W); code++)
         send_beat(FUNC_W'(code), ID_W'($urandom), $urandom, $urandom);
      send_beat(FUNC_CLEAR_ALL, ID_W'($urandom), $urandom, $urandom);
      send_beat(FUNC_QUERY, 4'd0, $urandom, $urandom);
   endtask

   task automatic test_random_traffic(input int count, input int pct);
      int                pick;
      logic [FUNC_W-1:0] op_func;
      logic [ID_W-1:0]   op_id;
      logic [TIME_W-1:0] op_period;
      logic [TIME_W-1:0] op_now;
      idle_pct = pct;
      repeat (count) begin
         pick      = $urandom_range(99);
         op_id     = ID_W'($urandom_range(NUM_TIMERS - 1));
         op_period = $urandom;
         if (pick < 30) begin
            op_func = FUNC_TICK;
            ms_now  = ms_now + $urandom_range(0, 8);
            if ($urandom_range(19) == 0) ms_now = $urandom;
         end else if (pick < 45) begin
            op_func = (pick < 38) ? FUNC_SET_ONCE : FUNC_SET_REP;
            case ($urandom_range(19))
               0:       op_period = '0;
               1:       op_period = '1;
               2, 3:    op_period = $urandom;
               default: op_period = $urandom_range(0, 40);
            endcase
         end else if (pick < 57) op_func = FUNC_START;
         else if (pick < 63) op_func = FUNC_STOP;
         else if (pick < 69) op_func = FUNC_RESTART;
         else if (pick < 81) op_func = FUNC_QUERY;
         else if (pick < 93) op_func = FUNC_ELAPSED;
         else if (pick < 95) op_func = FUNC_CLEAR_ALL;
         else op_func = FUNC_W'($urandom_range(FUNC_TICK + 1, (1 << FUNC_W) - 1));
         op_now = ms_now;
         if (op_func != FUNC_TICK && $urandom_range(24) == 0) op_now = $urandom;
         send_beat(op_func, op_id, op_period, op_now);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_data.elapsed_ms, '0);
         end else begin
            want = awaited_results.pop_front();
            results_checked++;
            if (rsp_data.flag_mask != '0) flagged_results++;
            if (rsp_data.timeout_flag !== want.timeout_flag)
               report_mismatch("timeout_flag", TIME_W'(rsp_data.timeout_flag),
                               TIME_W'(want.timeout_flag));
            if (rsp_data.elapsed_ms !== want.elapsed_ms)
               report_mismatch("elapsed_ms", rsp_data.elapsed_ms, want.elapsed_ms);
            if (rsp_data.flag_mask !== want.flag_mask)
               report_mismatch("flag_mask", TIME_W'(rsp_data.flag_mask),
                               TIME_W'(want.flag_mask));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, awaited_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      idle_pct        = 0;
      error_count     = 0;
      ops_sent        = 0;
      ticks_sent      = 0;
      results_checked = 0;
      flagged_results = 0;
      quiet_cycles    = 0;
      ms_now          = '0;
      bank_clear();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_basic_operations();
      test_unused_codes_and_clear();
      wait_for_results();

      ms_now = 32'h0000_1000;
      test_random_traffic(242, 0);
      wait_for_results();
      ms_now = 32'hFFFF_FF80;
      test_random_traffic(242, 78);
      wait_for_results();
      test_random_traffic(242, 23);
      wait_for_results();

      $display("Ran %0d operations including %0d ticks; %0d results checked, %0d with flags set.",
               ops_sent, ticks_sent, results_checked, flagged_results);
      $display("Mismatches: %0d.", error_count);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
